>>> hw/rtl/fbde_pkg.sv
//------------------------------------------------------------------------------
// fbde_pkg: shared types and constants for the frame-store draw engine
// Holds the item structs, action codes, screen geometry and the
// controller-to-datapath command and status types.
//------------------------------------------------------------------------------
package fbde_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_DEPTH   = 1024;
  localparam int ADDR_W        = 10;
  localparam int DATA_W        = 8;
  localparam logic [2:0] ROW_MASK = 3'b111;

  typedef enum logic [2:0] {
    ACT_PIXEL = 3'd0,
    ACT_LINE  = 3'd1,
    ACT_RECT  = 3'd2,
    ACT_FILL  = 3'd3,
    ACT_HRUN  = 3'd4,
    ACT_VRUN  = 3'd5,
    ACT_READ  = 3'd6,
    ACT_NOP   = 3'd7
  } action_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic       pen_value;
    logic       filled;
    logic [9:0] byte_addr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       was_read;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_READ,
    ST_RMW_WRITE,
    ST_DONE
  } state_t;

  // Sweep modes: what the datapath's point generator walks over.
  typedef enum logic [1:0] {
    MODE_LINE,
    MODE_BOX,
    MODE_ALL
  } mode_t;

  typedef struct packed {
    logic load;      // latch item and start a walk
    logic step;      // advance the walk to the next point
    logic rd_en;     // read the byte under the current point
    logic wr_en;     // write back the modified byte
    logic clr_en;    // write zero at the clear counter
    logic clr_step;  // advance the clear counter
    logic cap_read;  // capture read data into the result
  } dp_cmd_t;

  typedef struct packed {
    logic last;      // current point is the last of the walk
    logic clr_done;  // clear counter at its final entry
    logic is_read;
  } dp_sts_t;

endpackage

>>> hw/rtl/framebuffer_draw_engine.sv
//------------------------------------------------------------------------------
// framebuffer_draw_engine: monochrome frame-store draw engine
// Draws pixels, lines, rectangles, runs and fills into a 1024-byte store.
//------------------------------------------------------------------------------
// Usage: an item on the in_ channel (valid/stall) carries one command; each
// item returns exactly one result on the out_ channel. Only a read command
// returns data; all others return zero with was_read low.
// After reset the block sweeps all 1024 bytes of the frame store to zero,
// holding in_stall high; then it takes items.
// Items are handled one at a time. Each drawn on-screen pixel is a read
// then a write of the single-port store; each clipped point is skipped
// without a store access, and an empty command ends at its first point.
// The result stays on out_ while out_stall is high; the next item
// can be accepted in the cycle after the result is taken.
//------------------------------------------------------------------------------
module framebuffer_draw_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbde_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbde_pkg::out_item_t out_data
);

  fbde_pkg::dp_cmd_t cmd;
  fbde_pkg::dp_sts_t sts;
  logic              skip;

  fbde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .skip      (skip),
    .cmd       (cmd)
  );

  fbde_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .skip    (skip),
    .result  (out_data)
  );

endmodule

>>> hw/rtl/fbde_ram.sv
//------------------------------------------------------------------------------
// fbde_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
//------------------------------------------------------------------------------
module fbde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage array with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/fbde_datapath.sv
//------------------------------------------------------------------------------
// fbde_datapath: point generator, read-modify-write and result register
// Walks the points of a command (Bresenham line or clipped box raster),
// updates the frame store one pixel at a time, and sweeps the store at reset.
//------------------------------------------------------------------------------
module fbde_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fbde_pkg::in_item_t    in_item,
  input  fbde_pkg::dp_cmd_t     cmd,
  output fbde_pkg::dp_sts_t     sts,
  output logic                  skip,
  output fbde_pkg::out_item_t   result
);

  // Latched command data.
  fbde_pkg::mode_t mode_r, mode_nxt;
  logic            pen_r;
  logic            is_read_r;
  logic [9:0]      raddr_r;
  logic            empty_r;

  // Current point (10 bits holds coordinates up to 509, the largest box edge, without wrap).
  logic [9:0] cx_r, cy_r;
  // Box bounds, inclusive.
  logic [9:0] bx0_r, bx1_r, by0_r, by1_r;
  logic       boxfill_r;
  // Bresenham terms.
  logic [7:0]        lx1_r, ly1_r;
  logic signed [9:0] dx_r, dy_r;
  logic signed [10:0] err_r;
  logic              sx_r, sy_r;

  logic [9:0] clr_r;
  fbde_pkg::out_item_t result_r;

  logic [7:0] ax, ay, bx, by;
  assign ax = in_item.x_a;
  assign ay = in_item.y_a;
  assign bx = in_item.x_b;
  assign by = in_item.y_b;

  // Decode of a new command into a walk description.
  logic [9:0] nbx0, nbx1, nby0, nby1;
  logic       nempty, nfill;
  always_comb begin
    mode_nxt = fbde_pkg::MODE_BOX;
    nbx0 = {2'b0, ax};
    nbx1 = {2'b0, ax};
    nby0 = {2'b0, ay};
    nby1 = {2'b0, ay};
    nempty = 1'b0;
    nfill  = 1'b1;
    case (in_item.action)
      fbde_pkg::ACT_LINE: mode_nxt = fbde_pkg::MODE_LINE;
      fbde_pkg::ACT_RECT: begin
        nbx1 = {2'b0, ax} + {2'b0, bx} - 10'd1;
        nby1 = {2'b0, ay} + {2'b0, by} - 10'd1;
        nempty = (bx == 8'd0) || (by == 8'd0);
        nfill  = in_item.filled;
      end
      fbde_pkg::ACT_FILL: mode_nxt = fbde_pkg::MODE_ALL;
      fbde_pkg::ACT_HRUN: begin
        nbx1 = {2'b0, bx};
        nempty = bx < ax;
      end
      fbde_pkg::ACT_VRUN: begin
        nby1 = {2'b0, by};
        nempty = by < ay;
      end
      fbde_pkg::ACT_PIXEL: ;
      default: nempty = 1'b1;
    endcase
  end

  // Walk position bookkeeping.
  logic on_edge_x, on_edge_y, last_box, last_line;
  logic [9:0] nxt_box_x, nxt_box_y;
  logic row_end;
  assign on_edge_y = (cy_r == by0_r) || (cy_r == by1_r);
  assign row_end   = (cy_r == by1_r);
  // In outline mode, interior columns jump from top straight to bottom.
  always_comb begin
    nxt_box_y = cy_r + 10'd1;
    nxt_box_x = cx_r;
    on_edge_x = (cx_r == bx0_r) || (cx_r == bx1_r);
    if (row_end) begin
      nxt_box_y = by0_r;
      nxt_box_x = cx_r + 10'd1;
    end else if (!boxfill_r && !on_edge_x) begin
      nxt_box_y = by1_r;
    end
  end
  assign last_box  = row_end && (cx_r == bx1_r);
  assign last_line = (cx_r[7:0] == lx1_r) && (cy_r[7:0] == ly1_r);

  logic signed [11:0] e2;
  assign e2 = {err_r, 1'b0};

  // Point registers and walk state.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode_nxt;
      pen_r     <= in_item.pen_value;
      is_read_r <= (in_item.action == fbde_pkg::ACT_READ);
      raddr_r   <= in_item.byte_addr;
      empty_r   <= nempty;
      boxfill_r <= nfill;
      lx1_r     <= bx;
      ly1_r     <= by;
      sx_r      <= ax < bx;
      sy_r      <= ay < by;
      dx_r      <= (bx > ax) ? 10'($signed({2'b0, bx - ax})) : 10'($signed({2'b0, ax - bx}));
      dy_r      <= (by > ay) ? 10'($signed({2'b0, by - ay})) : 10'($signed({2'b0, ay - by}));
      err_r     <= 11'(((bx > ax) ? {3'b0, bx - ax} : {3'b0, ax - bx}))
                 - 11'(((by > ay) ? {3'b0, by - ay} : {3'b0, ay - by}));
      if (mode_nxt == fbde_pkg::MODE_ALL) begin
        bx0_r <= 10'd0;
        bx1_r <= 10'(fbde_pkg::SCREEN_WIDTH - 1);
        by0_r <= 10'd0;
        by1_r <= 10'(fbde_pkg::SCREEN_HEIGHT - 1);
        cx_r  <= 10'd0;
        cy_r  <= 10'd0;
      end else begin
        bx0_r <= nbx0;
        bx1_r <= nbx1;
        by0_r <= nby0;
        by1_r <= nby1;
        cx_r  <= {2'b0, ax};
        cy_r  <= {2'b0, ay};
      end
    end else if (cmd.step) begin
      if (mode_r == fbde_pkg::MODE_LINE) begin
        if ((e2 > -12'(dy_r)) && (e2 < 12'(dx_r))) begin
          err_r <= err_r - 11'(dy_r) + 11'(dx_r);
        end else if (e2 > -12'(dy_r)) begin
          err_r <= err_r - 11'(dy_r);
        end else if (e2 < 12'(dx_r)) begin
          err_r <= err_r + 11'(dx_r);
        end
        if (e2 > -12'(dy_r)) begin
          cx_r <= sx_r ? cx_r + 10'd1 : cx_r - 10'd1;
        end
        if (e2 < 12'(dx_r)) begin
          cy_r <= sy_r ? cy_r + 10'd1 : cy_r - 10'd1;
        end
      end else begin
        cx_r <= nxt_box_x;
        cy_r <= nxt_box_y;
      end
    end
  end

  // Clip and address of the current point.
  logic on_screen;
  logic [9:0] pix_addr;
  assign on_screen = !empty_r && (cx_r < 10'(fbde_pkg::SCREEN_WIDTH))
                     && (cy_r < 10'(fbde_pkg::SCREEN_HEIGHT));
  assign pix_addr  = {cx_r[6:0], cy_r[5:3]};
  assign skip      = !on_screen;

  // Frame store access.
  logic       we;
  logic [9:0] addr;
  logic [7:0] wdata, rdata, bitmask;
  assign bitmask = 8'd1 << (cy_r[2:0] & fbde_pkg::ROW_MASK);
  always_comb begin
    we    = 1'b0;
    addr  = pix_addr;
    wdata = pen_r ? (rdata | bitmask) : (rdata & ~bitmask);
    if (cmd.clr_en) begin
      we    = 1'b1;
      addr  = clr_r;
      wdata = 8'd0;
    end else if (cmd.wr_en) begin
      we = 1'b1;
    end else if (cmd.rd_en && is_read_r) begin
      addr = raddr_r;
    end
  end

  fbde_ram #(.WIDTH(fbde_pkg::DATA_W), .DEPTH(fbde_pkg::STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Clear counter swept after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 10'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_r <= '0;
    end else if (cmd.cap_read) begin
      result_r.read_data <= rdata;
      result_r.was_read  <= 1'b1;
    end
  end

  // An empty command ends at its first point instead of walking its bounds.
  assign result       = result_r;
  assign sts.last     = empty_r ||
                        ((mode_r == fbde_pkg::MODE_LINE) ? last_line : last_box);
  assign sts.clr_done = (clr_r == 10'(fbde_pkg::STORE_DEPTH - 1));
  assign sts.is_read  = is_read_r;

  // on_edge_y is used for checking the outline walk below.
`ifndef SYNTHESIS
  a_outline_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !boxfill_r && mode_r == fbde_pkg::MODE_BOX && !on_edge_x)
      |-> on_edge_y)
    else $error("outline walk left the box edge");
  a_no_wr_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_en && cmd.wr_en))
    else $error("clear and pixel write in one cycle");
  a_clr_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_step && sts.clr_done) |=> (clr_r == 10'd0))
    else $error("clear counter did not wrap");
`endif

endmodule

>>> hw/rtl/fbde_ctrl.sv
//------------------------------------------------------------------------------
// fbde_ctrl: command sequencer
// Clears the store after reset, then runs each draw item as read-modify-write
// pixel updates, a read item as one read, and hands one result to the output.
//------------------------------------------------------------------------------
module fbde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fbde_pkg::dp_sts_t sts,
  input  logic              skip,
  output fbde_pkg::dp_cmd_t cmd
);

  fbde_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbde_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      fbde_pkg::ST_CLEAR: begin
        cmd.clr_en   = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = fbde_pkg::ST_IDLE;
        end
      end
      fbde_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fbde_pkg::ST_RUN;
        end
      end
      fbde_pkg::ST_RUN: begin
        if (sts.is_read) begin
          cmd.rd_en = 1'b1;
          state_nxt = fbde_pkg::ST_READ;
        end else if (skip) begin
          if (sts.last) begin
            state_nxt = fbde_pkg::ST_DONE;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = fbde_pkg::ST_RMW_WRITE;
        end
      end
      fbde_pkg::ST_READ: begin
        cmd.cap_read = 1'b1;
        state_nxt    = fbde_pkg::ST_DONE;
      end
      fbde_pkg::ST_RMW_WRITE: begin
        cmd.wr_en = 1'b1;
        if (sts.last) begin
          state_nxt = fbde_pkg::ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = fbde_pkg::ST_RUN;
        end
      end
      fbde_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = fbde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fbde_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result delivered twice");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("accepting while a result is pending");
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(cmd.clr_en) |-> (state_r == fbde_pkg::ST_IDLE))
    else $error("clear sweep ended early");
`endif

endmodule

>>> dv/tb_framebuffer_draw_engine.sv
//------------------------------------------------------------------------------
// tb_framebuffer_draw_engine: self-checking bench for the draw engine
// Sends draw and read commands, tracks its own copy of the frame store and
// checks every returned item against it, with random idling on both sides.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_framebuffer_draw_engine;

  // Frame-store model and queue of expected results.
  class frame_scoreboard;
    logic [7:0] pixels [0:fbde_pkg::STORE_DEPTH-1];
    fbde_pkg::out_item_t pending_results [$];
    int         error_count;

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      error_count = 0;
    endfunction

    function void plot(int x, int y, logic pen);
      int idx;
      if (x < 0 || y < 0 || x >= fbde_pkg::SCREEN_WIDTH || y >= fbde_pkg::SCREEN_HEIGHT)
        return;
      idx = ((x << 3) + (y >> 3)) & (fbde_pkg::STORE_DEPTH - 1);
      pixels[idx][y & 7] = pen;
    endfunction

    function void trace_line(int x0, int y0, int x1, int y1, logic pen);
      int dx, dy, sx, sy, err, e2;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      forever begin
        plot(x0, y0, pen);
        if (x0 == x1 && y0 == y1) break;
        e2 = err * 2;
        if (e2 > -dy) begin
          err -= dy;
          x0 += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y0 += sy;
        end
      end
    endfunction

    // Apply one accepted command and queue the result it must return.
    function void note_command(fbde_pkg::in_item_t cmd);
      fbde_pkg::out_item_t res;
      int xa, ya, xb, yb;
      xa = cmd.x_a;
      ya = cmd.y_a;
      xb = cmd.x_b;
      yb = cmd.y_b;
      res = '0;
      case (fbde_pkg::action_t'(cmd.action))
        fbde_pkg::ACT_PIXEL: plot(xa, ya, cmd.pen_value);
        fbde_pkg::ACT_LINE:  trace_line(xa, ya, xb, yb, cmd.pen_value);
        fbde_pkg::ACT_RECT: begin
          // Here x_b is the width and y_b the height.
          if (xb != 0 && yb != 0) begin
            for (int x = xa; x < xa + xb; x++) begin
              plot(x, ya, cmd.pen_value);
              plot(x, ya + yb - 1, cmd.pen_value);
            end
            for (int y = ya; y < ya + yb; y++) begin
              plot(xa, y, cmd.pen_value);
              plot(xa + xb - 1, y, cmd.pen_value);
            end
            if (cmd.filled)
              for (int x = xa + 1; x < xa + xb - 1; x++)
                for (int y = ya + 1; y < ya + yb - 1; y++)
                  plot(x, y, cmd.pen_value);
          end
        end
        fbde_pkg::ACT_FILL:
          for (int y = 0; y < fbde_pkg::SCREEN_HEIGHT; y++)
            for (int x = 0; x < fbde_pkg::SCREEN_WIDTH; x++)
              plot(x, y, cmd.pen_value);
        fbde_pkg::ACT_HRUN: for (int x = xa; x <= xb; x++) plot(x, ya, cmd.pen_value);
        fbde_pkg::ACT_VRUN: for (int y = ya; y <= yb; y++) plot(xa, y, cmd.pen_value);
        fbde_pkg::ACT_READ: begin
          res.read_data = pixels[cmd.byte_addr];
          res.was_read  = 1'b1;
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(fbde_pkg::out_item_t got);
      fbde_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data mismatch, expected %h, actual %h",
                 $time, want.read_data, got.read_data);
        error_count++;
      end
      if (got.was_read !== want.was_read) begin
        $display("%0t: was_read mismatch, expected %b, actual %b",
                 $time, want.was_read, got.was_read);
        error_count++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3_000_000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fbde_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  fbde_pkg::out_item_t out_data;

  frame_scoreboard board;
  int sender_idle_pct;
  int receiver_idle_pct;
  int cycle_count;

  framebuffer_draw_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stall, check each item taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one command and hold it until taken, idling first at random.
  // Valid stays high after an acceptance only when the next item follows.
  task automatic send_command(fbde_pkg::in_item_t cmd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    board.note_command(cmd);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic fbde_pkg::in_item_t make_command(fbde_pkg::action_t act, int xa,
                                                      int ya, int xb, int yb, bit pen,
                                                      bit fill, int addr);
    fbde_pkg::in_item_t cmd;
    cmd.action    = act;
    cmd.x_a       = 8'(xa);
    cmd.y_a       = 8'(ya);
    cmd.x_b       = 8'(xb);
    cmd.y_b       = 8'(yb);
    cmd.pen_value = pen;
    cmd.filled    = fill;
    cmd.byte_addr = 10'(addr);
    return cmd;
  endfunction

  // Mostly small on-screen shapes; fills are rare because they are slow.
  function automatic fbde_pkg::in_item_t random_command();
    fbde_pkg::in_item_t cmd;
    int pick;
    cmd = fbde_pkg::in_item_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 10) cmd.action = fbde_pkg::ACT_PIXEL;
    else if (pick < 25) cmd.action = fbde_pkg::ACT_LINE;
    else if (pick < 40) cmd.action = fbde_pkg::ACT_RECT;
    else if (pick < 41) cmd.action = fbde_pkg::ACT_FILL;
    else if (pick < 52) cmd.action = fbde_pkg::ACT_HRUN;
    else if (pick < 63) cmd.action = fbde_pkg::ACT_VRUN;
    else if (pick < 97) cmd.action = fbde_pkg::ACT_READ;
    else cmd.action = fbde_pkg::ACT_NOP;
    if (cmd.action == fbde_pkg::ACT_FILL && $urandom_range(3) != 0)
      cmd.action = fbde_pkg::ACT_READ;
    if ($urandom_range(9) != 0) begin
      cmd.x_a = 8'($urandom_range(fbde_pkg::SCREEN_WIDTH - 1));
      cmd.y_a = 8'($urandom_range(fbde_pkg::SCREEN_HEIGHT - 1));
      if (cmd.action == fbde_pkg::ACT_RECT) begin
        cmd.x_b = 8'($urandom_range(24));
        cmd.y_b = 8'($urandom_range(24));
      end else begin
        cmd.x_b = 8'($urandom_range(fbde_pkg::SCREEN_WIDTH - 1));
        cmd.y_b = 8'($urandom_range(fbde_pkg::SCREEN_HEIGHT - 1));
      end
      if (cmd.action == fbde_pkg::ACT_READ && $urandom_range(3) != 0)
        cmd.byte_addr = 10'($urandom_range(fbde_pkg::SCREEN_WIDTH * 8 - 1));
    end
    return cmd;
  endfunction

  // Directed corners.
  task automatic run_directed();
    send_command(make_command(fbde_pkg::ACT_READ, 0, 0, 0, 0, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_PIXEL, 0, 0, 0, 0, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_PIXEL, 127, 63, 0, 0, 1, 1, 0));
    send_command(make_command(fbde_pkg::ACT_PIXEL, 255, 255, 255, 255, 1, 1, 1023));
    send_command(make_command(fbde_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(fbde_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1023));
    send_command(make_command(fbde_pkg::ACT_LINE, 0, 0, 127, 63, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_LINE, 200, 3, 5, 250, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_LINE, 9, 9, 9, 9, 0, 0, 0));
    send_command(make_command(fbde_pkg::ACT_RECT, 10, 10, 0, 5, 1, 1, 0));
    send_command(make_command(fbde_pkg::ACT_RECT, 10, 10, 5, 0, 1, 1, 0));
    send_command(make_command(fbde_pkg::ACT_RECT, 20, 5, 30, 20, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_RECT, 250, 250, 255, 255, 1, 1, 0));
    send_command(make_command(fbde_pkg::ACT_RECT, 120, 60, 20, 20, 1, 1, 0));
    send_command(make_command(fbde_pkg::ACT_HRUN, 100, 5, 255, 0, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_HRUN, 50, 5, 10, 0, 0, 0, 0));
    send_command(make_command(fbde_pkg::ACT_VRUN, 7, 0, 0, 255, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_VRUN, 7, 40, 0, 30, 0, 0, 0));
    send_command(make_command(fbde_pkg::ACT_NOP, 255, 255, 255, 255, 1, 1, 1023));
    send_command(make_command(fbde_pkg::ACT_READ, 0, 0, 0, 0, 1, 0, 56));
    send_command(make_command(fbde_pkg::ACT_FILL, 0, 0, 0, 0, 1, 0, 0));
    send_command(make_command(fbde_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1023));
    send_command(make_command(fbde_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 517));
    send_command(make_command(fbde_pkg::ACT_FILL, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(fbde_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 8));
  endtask

  initial begin
    board = new();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    // Pause until every expected result is back.
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 36 : (phase == 1) ? 70 : 0;
      receiver_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 36 : 0;
      repeat (342) send_command(random_command());
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (board.error_count == 0 && board.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/fbde_pkg.sv
hw/rtl/fbde_ram.sv
hw/rtl/fbde_datapath.sv
hw/rtl/fbde_ctrl.sv
hw/rtl/framebuffer_draw_engine.sv
dv/tb_framebuffer_draw_engine.sv
